FILE: sv/cgs_pkg.sv
package cgs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 10;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int DW         = COORD_BITS + 1;
  localparam int RW         = 2 * DW + 1;

  typedef struct packed {
    logic [9:0] point_x;
    logic [9:0] point_y;
    logic       last_point;
  } cgs_in_t;

  typedef struct packed {
    logic [5:0] point_index;
    logic       on_hull;
    logic       last_result;
  } cgs_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } cgs_pt_t;

  // r = a1*a2 - b1*b2 (sub) or a1*a2 + b1*b2
  typedef struct packed {
    logic signed [DW-1:0] a1;
    logic signed [DW-1:0] a2;
    logic signed [DW-1:0] b1;
    logic signed [DW-1:0] b2;
    logic                 sub;
  } cgs_ops_t;

  function automatic logic signed [DW-1:0] cdiff(logic [COORD_BITS-1:0] p,
                                                 logic [COORD_BITS-1:0] q);
    cdiff = $signed({1'b0, p}) - $signed({1'b0, q});
  endfunction

  // turn a->b->c, negative is counterclockwise
  function automatic cgs_ops_t mk_turn(cgs_pt_t a, cgs_pt_t b, cgs_pt_t c);
    cgs_ops_t o;
    o.a1  = cdiff(b.y, a.y);
    o.a2  = cdiff(c.x, b.x);
    o.b1  = cdiff(b.x, a.x);
    o.b2  = cdiff(c.y, b.y);
    o.sub = 1'b1;
    mk_turn = o;
  endfunction

  function automatic cgs_ops_t mk_dist(cgs_pt_t a, cgs_pt_t b);
    cgs_ops_t o;
    o.a1  = cdiff(a.x, b.x);
    o.a2  = cdiff(a.x, b.x);
    o.b1  = cdiff(a.y, b.y);
    o.b2  = cdiff(a.y, b.y);
    o.sub = 1'b0;
    mk_dist = o;
  endfunction

endpackage

FILE: sv/convex_hull_graham_scan_core.sv
// Channel | Ports                      | Handshake
// input   | in_data (cgs_in_t)         | start && !busy
// result  | out_data (cgs_out_t)       | out_valid, one cycle, no stall
//
// A plain point is stored while the core stays idle. A last point starts the run:
// pivot search, ordering (insertion sort, O(n^2)), scan (turn tests),
// marking, then n results. The shared two-stage multiply unit computes all
// turn and distance products. busy is high from the last point until the
// final result. Synchronous active-low reset; the receiver cannot stall.
module convex_hull_graham_scan_core import cgs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cgs_in_t  in_data,
  output logic     out_valid,
  output cgs_out_t out_data
);

  localparam logic [5:0] IDLE = 6'd0,  P_RD = 6'd1,  P_CMP = 6'd2, F0 = 6'd3,
                         FILL = 6'd4,  S_KA = 6'd5,  S_KB = 6'd6,  S_KC = 6'd7,
                         S_J  = 6'd8,  S_JB = 6'd9,  S_JC = 6'd10, S_T0 = 6'd11,
                         S_TW = 6'd12, S_TR = 6'd13, S_D1W = 6'd14, S_D1R = 6'd15,
                         S_D2W = 6'd16, S_D2R = 6'd17, S_INS = 6'd18, C_I0 = 6'd19,
                         C_I1 = 6'd20, C_A = 6'd21,  C_B = 6'd22,  C_C = 6'd23,
                         C_L  = 6'd24, C_L2 = 6'd25, C_L3 = 6'd26, C_W = 6'd27,
                         C_R  = 6'd28, C_P = 6'd29,  M_A = 6'd30,  M_B = 6'd31,
                         M_C  = 6'd32, M_D = 6'd33,  M_E = 6'd34,  EMIT = 6'd35;

  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_POINTS);
  localparam logic [CNT_W-1:0] ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] THR  = CNT_W'(3);

  logic [5:0]       st_r;
  logic [CNT_W-1:0] cnt_r, n_r, i_r, j_r, k_r, m_r, d_r;
  logic [IDX_W-1:0] piv_idx_r, key_r, s_r, cidx_r;
  cgs_pt_t          piv_r, keyp_r, sp_r, cp_r, h_r;
  logic signed [RW-1:0] da_r;
  logic [MAX_POINTS-1:0] mark_r;

  cgs_pt_t          pts [MAX_POINTS];
  logic [IDX_W-1:0] srt [MAX_POINTS];
  logic [IDX_W-1:0] stk [MAX_POINTS];
  cgs_pt_t          pts_qa, pts_qb;
  logic [IDX_W-1:0] srt_q, stk_qa, stk_qb;

  logic [IDX_W-1:0] pa_addr, pb_addr, sr_addr, ka_addr, kb_addr;
  logic             srt_we, stk_we;
  logic [IDX_W-1:0] srt_wa, srt_wd, stk_wa, stk_wd;

  cgs_ops_t             ops;
  logic signed [RW-1:0] mres;

  logic             accept, move;
  logic [CNT_W-1:0] cnt_nxt;
  cgs_pt_t          in_pt;

  cgs_mac u_mac (.clk(clk), .ops(ops), .res(mres));

  assign accept    = start && !busy;
  assign busy      = (st_r != IDLE);
  assign cnt_nxt   = (cnt_r < MAXC) ? cnt_r + ONE : cnt_r;
  assign in_pt.x   = in_data.point_x[COORD_BITS-1:0];
  assign in_pt.y   = in_data.point_y[COORD_BITS-1:0];

  // key goes before the compared entry
  always_comb begin
    move = 1'b0;
    if (st_r == S_TR) begin
      move = (mres < 0);
    end else if (st_r == S_D2R) begin
      move = (da_r < mres);
    end
  end

  always_comb begin
    unique case (st_r)
      S_T0:    ops = mk_turn(piv_r, keyp_r, sp_r);
      S_TR:    ops = mk_dist(piv_r, keyp_r);
      S_D1R:   ops = mk_dist(piv_r, sp_r);
      default: ops = mk_turn(pts_qa, pts_qb, cp_r);
    endcase
  end

  always_comb begin
    pa_addr = i_r[IDX_W-1:0];
    pb_addr = stk_qb;
    sr_addr = i_r[IDX_W-1:0];
    ka_addr = k_r[IDX_W-1:0];
    kb_addr = 6'(d_r - ONE);
    unique case (st_r)
      S_KB, S_JB, C_B: pa_addr = srt_q;
      C_L2, M_B:       pa_addr = stk_qa;
      M_D:             pa_addr = m_r[IDX_W-1:0];
      default:         pa_addr = i_r[IDX_W-1:0];
    endcase
    if (st_r == S_J) sr_addr = 6'(j_r - ONE);
    if (st_r == C_L) ka_addr = 6'(d_r - TWO);
  end

  always_comb begin
    srt_we = 1'b0;
    srt_wa = j_r[IDX_W-1:0];
    srt_wd = i_r[IDX_W-1:0];
    stk_we = 1'b0;
    stk_wa = d_r[IDX_W-1:0];
    stk_wd = cidx_r;
    unique case (st_r)
      F0: begin
        srt_we = 1'b1;
        srt_wa = '0;
        srt_wd = piv_idx_r;
      end
      FILL:  srt_we = (i_r[IDX_W-1:0] != piv_idx_r);
      S_TR, S_D2R: begin
        srt_we = move && (st_r == S_D2R || mres != 0);
        srt_wd = s_r;
      end
      S_INS: begin
        srt_we = 1'b1;
        srt_wd = key_r;
      end
      C_I1: begin
        stk_we = 1'b1;
        stk_wa = i_r[IDX_W-1:0];
        stk_wd = srt_q;
      end
      C_P:     stk_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && cnt_r < MAXC) pts[cnt_r[IDX_W-1:0]] <= in_pt;
    pts_qa <= pts[pa_addr];
    pts_qb <= pts[pb_addr];
    if (srt_we) srt[srt_wa] <= srt_wd;
    srt_q <= srt[sr_addr];
    if (stk_we) stk[stk_wa] <= stk_wd;
    stk_qa <= stk[ka_addr];
    stk_qb <= stk[kb_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= IDLE;
      cnt_r <= '0;
    end else begin
      unique case (st_r)
        IDLE: if (accept) begin
          cnt_r <= cnt_nxt;
          if (in_data.last_point) begin
            n_r <= cnt_nxt;
            i_r <= '0;
            m_r <= '0;
            if (cnt_nxt < THR) begin
              mark_r <= '1;
              st_r   <= EMIT;
            end else begin
              mark_r <= '0;
              st_r   <= P_RD;
            end
          end
        end
        P_RD: st_r <= P_CMP;
        P_CMP: begin
          if (i_r == '0 || pts_qa.y < piv_r.y ||
              (pts_qa.y == piv_r.y && pts_qa.x < piv_r.x)) begin
            piv_r     <= pts_qa;
            piv_idx_r <= i_r[IDX_W-1:0];
          end
          if (i_r + ONE == n_r) begin
            st_r <= F0;
          end else begin
            i_r  <= i_r + ONE;
            st_r <= P_RD;
          end
        end
        F0: begin
          i_r  <= '0;
          j_r  <= ONE;
          st_r <= FILL;
        end
        FILL: begin
          if (i_r[IDX_W-1:0] != piv_idx_r) j_r <= j_r + ONE;
          if (i_r + ONE == n_r) begin
            i_r  <= TWO;
            st_r <= S_KA;
          end else begin
            i_r <= i_r + ONE;
          end
        end
        S_KA: st_r <= S_KB;
        S_KB: begin
          key_r <= srt_q;
          st_r  <= S_KC;
        end
        S_KC: begin
          keyp_r <= pts_qa;
          j_r    <= i_r;
          st_r   <= S_J;
        end
        S_J:  st_r <= (j_r > ONE) ? S_JB : S_INS;
        S_JB: begin
          s_r  <= srt_q;
          st_r <= S_JC;
        end
        S_JC: begin
          sp_r <= pts_qa;
          st_r <= S_T0;
        end
        S_T0: st_r <= S_TW;
        S_TW: st_r <= S_TR;
        S_TR: begin
          if (mres == 0) begin
            st_r <= S_D1W;
          end else if (move) begin
            j_r  <= j_r - ONE;
            st_r <= S_J;
          end else begin
            st_r <= S_INS;
          end
        end
        S_D1W: st_r <= S_D1R;
        S_D1R: begin
          da_r <= mres;
          st_r <= S_D2W;
        end
        S_D2W: st_r <= S_D2R;
        S_D2R: begin
          if (move) begin
            j_r  <= j_r - ONE;
            st_r <= S_J;
          end else begin
            st_r <= S_INS;
          end
        end
        S_INS: begin
          if (i_r + ONE == n_r) begin
            i_r  <= '0;
            st_r <= C_I0;
          end else begin
            i_r  <= i_r + ONE;
            st_r <= S_KA;
          end
        end
        C_I0: st_r <= C_I1;
        C_I1: begin
          if (i_r == TWO) begin
            d_r  <= THR;
            i_r  <= THR;
            st_r <= (n_r == THR) ? M_A : C_A;
            k_r  <= '0;
          end else begin
            i_r  <= i_r + ONE;
            st_r <= C_I0;
          end
        end
        C_A: st_r <= C_B;
        C_B: begin
          cidx_r <= srt_q;
          st_r   <= C_C;
        end
        C_C: begin
          cp_r <= pts_qa;
          st_r <= C_L;
        end
        C_L:  st_r <= (d_r > TWO) ? C_L2 : C_P;
        C_L2: st_r <= C_L3;
        C_L3: st_r <= C_W;
        C_W:  st_r <= C_R;
        C_R: begin
          // pop while the turn is not strictly counterclockwise
          if (mres >= 0) begin
            d_r  <= d_r - ONE;
            st_r <= C_L;
          end else begin
            st_r <= C_P;
          end
        end
        C_P: begin
          d_r <= d_r + ONE;
          if (i_r + ONE == n_r) begin
            k_r  <= '0;
            st_r <= M_A;
          end else begin
            i_r  <= i_r + ONE;
            st_r <= C_A;
          end
        end
        M_A: st_r <= M_B;
        M_B: st_r <= M_C;
        M_C: begin
          h_r  <= pts_qa;
          m_r  <= '0;
          st_r <= M_D;
        end
        M_D: st_r <= M_E;
        M_E: begin
          if (pts_qa == h_r) mark_r[m_r[IDX_W-1:0]] <= 1'b1;
          if (m_r + ONE == n_r) begin
            m_r <= '0;
            if (k_r + ONE == d_r) begin
              st_r <= EMIT;
            end else begin
              k_r  <= k_r + ONE;
              st_r <= M_A;
            end
          end else begin
            m_r  <= m_r + ONE;
            st_r <= M_D;
          end
        end
        EMIT: begin
          if (m_r + ONE == n_r) begin
            cnt_r <= '0;
            st_r  <= IDLE;
          end else begin
            m_r <= m_r + ONE;
          end
        end
        default: st_r <= IDLE;
      endcase
    end
  end

  assign out_valid            = (st_r == EMIT);
  assign out_data.point_index = m_r[IDX_W-1:0];
  assign out_data.on_hull     = mark_r[m_r[IDX_W-1:0]];
  assign out_data.last_result = (m_r + ONE == n_r);

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result outside run");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_result |=> !busy) else $error("run did not end");

  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_data.last_point |=> busy) else $error("run not started");

  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == C_R |-> d_r > TWO) else $error("stack below floor");

endmodule

FILE: sv/cgs_mac.sv
module cgs_mac import cgs_pkg::*; (
  input  logic                 clk,
  input  cgs_ops_t             ops,
  output logic signed [RW-1:0] res
);

  logic signed [2*DW-1:0] p1_r, p2_r;
  logic                   sub_r;
  logic signed [RW-1:0]   res_r;

  always_ff @(posedge clk) begin
    p1_r  <= ops.a1 * ops.a2;
    p2_r  <= ops.b1 * ops.b2;
    sub_r <= ops.sub;
    if (sub_r) begin
      res_r <= RW'(p1_r) - RW'(p2_r);
    end else begin
      res_r <= RW'(p1_r) + RW'(p2_r);
    end
  end

  assign res = res_r;

endmodule

FILE: test/convex_hull_graham_scan_core_tb.sv
module convex_hull_graham_scan_core_tb;
  import cgs_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  cgs_in_t  in_data;
  logic     out_valid;
  cgs_out_t out_data;

  convex_hull_graham_scan_core u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  localparam int CYCLE_LIMIT = 3000000;

  cgs_in_t  point_queue[$];
  int       pause_marks[$];  // driver waits for drain before this item index
  cgs_out_t marks_expected[$];

  // hull predictor state
  logic [9:0] set_x[MAX_POINTS];
  logic [9:0] set_y[MAX_POINTS];
  int         set_count;

  int  mismatches;
  bit  failed;
  int  cycles;
  int  sent_items;
  int  runs_done;
  int  results_seen;
  bit  stim_done;
  bit  calm_phase;
  int  gap_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint hull_turn(int ax, int ay, int bx, int by, int cx, int cy);
    return longint'(by - ay) * (cx - bx) - longint'(bx - ax) * (cy - by);
  endfunction

  // true when point a sorts strictly ahead of point b around the pivot
  function automatic bit sorts_ahead(int pvx, int pvy, int ax, int ay, int bx, int by);
    longint t;
    longint da;
    longint db;
    t = hull_turn(pvx, pvy, ax, ay, bx, by);
    da = longint'(ax - pvx) * (ax - pvx) + longint'(ay - pvy) * (ay - pvy);
    db = longint'(bx - pvx) * (bx - pvx) + longint'(by - pvy) * (by - pvy);
    if (t == 0) return da < db;
    return t < 0;
  endfunction

  task automatic predict_hull_marks();
    int order[MAX_POINTS];
    int stack[MAX_POINTS];
    int n;
    int piv;
    int j;
    int key;
    int depth;
    bit mark;
    cgs_out_t r;
    n = set_count;
    depth = 0;
    if (n >= 3) begin
      piv = 0;
      for (int i = 1; i < n; i++)
        if (set_y[i] < set_y[piv] || (set_y[i] == set_y[piv] && set_x[i] < set_x[piv]))
          piv = i;
      order[0] = piv;
      j = 1;
      for (int i = 0; i < n; i++)
        if (i != piv) begin
          order[j] = i;
          j++;
        end
      for (int i = 2; i < n; i++) begin
        key = order[i];
        j = i;
        while (j > 1 && sorts_ahead(set_x[piv], set_y[piv], set_x[key], set_y[key],
                                    set_x[order[j-1]], set_y[order[j-1]])) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = key;
      end
      stack[0] = order[0];
      stack[1] = order[1];
      stack[2] = order[2];
      depth = 3;
      for (int i = 3; i < n; i++) begin
        while (depth > 2 &&
               hull_turn(set_x[stack[depth-2]], set_y[stack[depth-2]],
                         set_x[stack[depth-1]], set_y[stack[depth-1]],
                         set_x[order[i]], set_y[order[i]]) >= 0)
          depth--;
        stack[depth] = order[i];
        depth++;
      end
    end
    for (int i = 0; i < n; i++) begin
      mark = (n < 3);
      for (int k = 0; k < depth; k++)
        if (set_x[stack[k]] == set_x[i] && set_y[stack[k]] == set_y[i]) mark = 1'b1;
      r.point_index = i[5:0];
      r.on_hull     = mark;
      r.last_result = (i == n - 1);
      marks_expected.push_back(r);
    end
    set_count = 0;
  endtask

  task automatic accept_point(cgs_in_t p);
    if (set_count < MAX_POINTS) begin
      set_x[set_count] = p.point_x;
      set_y[set_count] = p.point_y;
      set_count++;
    end
    if (p.last_point) begin
      predict_hull_marks();
      runs_done++;
    end
  endtask

  function automatic cgs_in_t mk_point(int x, int y, bit last);
    cgs_in_t p;
    p.point_x = x[9:0];
    p.point_y = y[9:0];
    p.last_point = last;
    return p;
  endfunction

  task automatic queue_set(int n, int span);
    int bx;
    int by;
    bx = $urandom_range(0, 1023 - span);
    by = $urandom_range(0, 1023 - span);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0 && i > 0)  // duplicate of the previous point
        point_queue.push_back(mk_point(point_queue[$].point_x, point_queue[$].point_y,
                                       i == n - 1));
      else
        point_queue.push_back(mk_point(bx + $urandom_range(0, span),
                                       by + $urandom_range(0, span), i == n - 1));
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_data <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) begin
        accept_point(in_data);
        sent_items++;
      end
      if (start && busy) begin
        // hold the pending transaction
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (point_queue.size() == 0) begin
        start <= 1'b0;
      end else if (pause_marks.size() > 0 && pause_marks[0] == sent_items &&
                   (marks_expected.size() > 0 || busy)) begin
        start <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
        start <= 1'b0;
        gap_left <= $urandom_range(0, 17);
      end else begin
        if (pause_marks.size() > 0 && pause_marks[0] <= sent_items)
          void'(pause_marks.pop_front());
        in_data <= point_queue.pop_front();
        start <= 1'b1;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (marks_expected.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result idx=%0d hull=%0b last=%0b",
                   out_data.point_index, out_data.on_hull, out_data.last_result);
      end else begin
        cgs_out_t e;
        e = marks_expected.pop_front();
        if (e !== out_data) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx=%0d hull=%0b last=%0b got idx=%0d hull=%0b last=%0b",
                     e.point_index, e.on_hull, e.last_result,
                     out_data.point_index, out_data.on_hull, out_data.last_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int total;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    set_count = 0;
    mismatches = 0;
    failed = 1'b0;
    cycles = 0;
    sent_items = 0;
    runs_done = 0;
    results_seen = 0;
    stim_done = 0;
    calm_phase = 0;
    // directed: single point, pair, triangle at extremes, collinear line, square
    point_queue.push_back(mk_point(1023, 1023, 1));
    point_queue.push_back(mk_point(0, 0, 0));
    point_queue.push_back(mk_point(1023, 0, 1));
    point_queue.push_back(mk_point(0, 0, 0));
    point_queue.push_back(mk_point(1023, 0, 0));
    point_queue.push_back(mk_point(0, 1023, 1));
    point_queue.push_back(mk_point(5, 5, 0));
    point_queue.push_back(mk_point(10, 10, 0));
    point_queue.push_back(mk_point(1, 1, 0));
    point_queue.push_back(mk_point(20, 20, 1));
    point_queue.push_back(mk_point(0, 0, 0));
    point_queue.push_back(mk_point(1023, 1023, 0));
    point_queue.push_back(mk_point(1023, 0, 0));
    point_queue.push_back(mk_point(0, 1023, 0));
    point_queue.push_back(mk_point(512, 512, 0));
    point_queue.push_back(mk_point(512, 0, 0));
    point_queue.push_back(mk_point(0, 0, 0));
    point_queue.push_back(mk_point(682, 341, 1));
    pause_marks.push_back(point_queue.size());
    // overflow: 66 points, the last two dropped, the last flag still starts the run
    for (int i = 0; i < 66; i++)
      point_queue.push_back(mk_point($urandom_range(0, 1023), $urandom_range(0, 1023),
                                     i == 65));
    pause_marks.push_back(point_queue.size());
    total = point_queue.size();
    while (point_queue.size() < total + 146) begin
      case ($urandom_range(0, 3))
        0: queue_set($urandom_range(1, 4), $urandom_range(1, 1023));
        1: queue_set($urandom_range(3, 12), $urandom_range(2, 15));
        default: queue_set($urandom_range(3, 20), 1023);
      endcase
      if ($urandom_range(0, 7) == 0) pause_marks.push_back(point_queue.size());
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    while (point_queue.size() > 40) @(posedge clk);
    calm_phase <= 1'b1;
    while (point_queue.size() > 0 || start) @(posedge clk);
    while (marks_expected.size() > 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("covered %0d points in %0d hull runs, %0d flags checked, %0d mismatches",
             sent_items, runs_done, results_seen, mismatches);
    if (!failed && marks_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
